// File: design/tce_pkg.sv
// ----------------------------------------------------------------------------
// tce_pkg
// Shared constants, codes and types of the text console character engine.
// ----------------------------------------------------------------------------
package tce_pkg;

	// Cell store geometry. The offset fields are 13 bits wide, so the store
	// depth is fixed here.
	localparam int STORE_CELLS = 8192;
	localparam int ADDR_W      = 13;
	localparam int CELL_W      = 16;
	localparam int ATTR_W      = 8;
	localparam int BYTE_W      = 8;
	localparam int OP_W        = 2;

	// Default screen geometry.
	localparam int COLUMNS_DEF  = 80;
	localparam int ROWS_DEF     = 25;
	localparam int TAB_STOP_DEF = 8;

	// Stream widths, padded to whole bytes.
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 48;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLANK_CELL = 1'd1;

	localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h02;
	localparam logic [CELL_W-1:0] BLANK_RESET = 16'h0720;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	// Control bytes.
	localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
	localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
	localparam logic [BYTE_W-1:0] CH_HT  = 8'h09;
	localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_VT  = 8'h0B;
	localparam logic [BYTE_W-1:0] CH_FF  = 8'h0C;
	localparam logic [BYTE_W-1:0] CH_DEL = 8'h7F;

	// Access to the cell store.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	// One finished transaction handed to the output register.
	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] shown;
		logic [ADDR_W-1:0] start;
		logic [CELL_W-1:0] data;
	} result_t;

endpackage

// File: design/text_console_char_engine.sv
// ----------------------------------------------------------------------------
// text_console_char_engine
// Teletype console engine for a text screen kept in a circular cell store.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_*       in         tuser: operation; tlast: last_of_write;
//                      tdata: char_byte, cell_address
// m_*       out        tdata: shown_cursor, screen_start, cell_data
// cfg_*     in         register write: text_attribute, blank_cell
//
// Reads and bytes that stay on the current row pass the decode and result
// states; a new line adds the new-line state, and a printable byte that
// first wraps adds a print state after it. A scroll adds the row erase, and
// a copy of the screen when it is moved back to the store base first.
// Clear walks the whole store, one cell a cycle. After reset the same walk
// blanks the store; no transaction is taken meanwhile. A finished result
// waits in the output register while the next transaction is accepted.
// ----------------------------------------------------------------------------
module text_console_char_engine #(
	parameter int Columns = tce_pkg::COLUMNS_DEF,
	parameter int Rows    = tce_pkg::ROWS_DEF,
	parameter int TabStop = tce_pkg::TAB_STOP_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [7:0] char_byte, [20:8] cell_address, [23:21] zero
	input  logic [tce_pkg::S_TDATA_W-1:0]     s_tdata,
	// [1:0] operation
	input  logic [tce_pkg::OP_W-1:0]          s_tuser,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [12:0] shown_cursor, [25:13] screen_start, [41:26] cell_data, [47:42] zero
	output logic [tce_pkg::M_TDATA_W-1:0]     m_tdata,
	input  logic                              cfg_we,
	input  logic [tce_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [tce_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	localparam int ADDR_W = tce_pkg::ADDR_W;
	localparam int PAD_W  = tce_pkg::M_TDATA_W - 2 * ADDR_W - tce_pkg::CELL_W;

	tce_pkg::result_t            res;
	tce_pkg::mem_req_t           mem_req;
	logic [tce_pkg::CELL_W-1:0]  rdata;
	logic                        out_free;
	logic                        m_tvalid_q;
	logic [tce_pkg::M_TDATA_W-1:0] m_tdata_q;

	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	tce_seq #(
		.Columns (Columns),
		.Rows    (Rows),
		.TabStop (TabStop)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_valid   (s_tvalid),
		.s_ready   (s_tready),
		.op_in     (s_tuser),
		.byte_in   (s_tdata[tce_pkg::BYTE_W-1:0]),
		.last_in   (s_tlast),
		.addr_in   (s_tdata[tce_pkg::BYTE_W +: ADDR_W]),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.out_free  (out_free),
		.res       (res),
		.mem_req   (mem_req),
		.rdata     (rdata)
	);

	tce_cell_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			m_tdata_q <= {{PAD_W{1'b0}}, res.data, res.start, res.shown};
		end
	end

endmodule

// File: design/tce_cell_ram.sv
// ----------------------------------------------------------------------------
// tce_cell_ram
// Cell store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tce_cell_ram (
	input  logic                         clk,
	input  tce_pkg::mem_req_t            req,
	output logic [tce_pkg::CELL_W-1:0]   rdata
);

	logic [tce_pkg::CELL_W-1:0] mem [tce_pkg::STORE_CELLS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// File: design/tce_seq.sv
// ----------------------------------------------------------------------------
// tce_seq
// Operation sequencer: decodes each transaction, keeps the cursor, screen
// start and configuration registers, and walks the cell store for scrolls,
// buffer wrap copies and clears.
// ----------------------------------------------------------------------------
module tce_seq #(
	parameter int Columns = tce_pkg::COLUMNS_DEF,
	parameter int Rows    = tce_pkg::ROWS_DEF,
	parameter int TabStop = tce_pkg::TAB_STOP_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_valid,
	output logic                             s_ready,
	input  logic [tce_pkg::OP_W-1:0]         op_in,
	input  logic [tce_pkg::BYTE_W-1:0]       byte_in,
	input  logic                             last_in,
	input  logic [tce_pkg::ADDR_W-1:0]       addr_in,
	input  logic                             cfg_we,
	input  logic [tce_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [tce_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                             out_free,
	output tce_pkg::result_t                 res,
	output tce_pkg::mem_req_t                mem_req,
	input  logic [tce_pkg::CELL_W-1:0]       rdata
);

	localparam int ADDR_W = tce_pkg::ADDR_W;
	localparam int SCREEN = Columns * Rows;
	localparam int COL_W  = $clog2(Columns + 2 * TabStop + 1);
	localparam int LINE_W = $clog2(Rows);
	localparam int PH_W   = $clog2(TabStop);
	localparam int CNT_W  = ADDR_W + 1;
	localparam int OVF_W  = ADDR_W + 2;
	localparam int COL_PH = Columns % TabStop;

	localparam logic [COL_W-1:0]  COLS_C     = COL_W'(Columns);
	localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(Columns);
	localparam logic [ADDR_W-1:0] SCREEN_A   = ADDR_W'(SCREEN);
	localparam logic [LINE_W-1:0] LAST_LINE  = LINE_W'(Rows - 1);
	localparam logic [CNT_W-1:0]  SCREEN_CNT = CNT_W'(SCREEN);
	localparam logic [CNT_W-1:0]  ERASE_LAST = CNT_W'(Columns - 1);
	localparam logic [ADDR_W-1:0] WIPE_LAST  = ADDR_W'(tce_pkg::STORE_CELLS - 1);
	localparam logic [PH_W-1:0]   PH_LAST    = PH_W'(TabStop - 1);
	localparam logic [PH_W-1:0]   PH_COL     = PH_W'(COL_PH);
	localparam logic [PH_W:0]     TAB_P      = (PH_W + 1)'(TabStop);
	localparam logic [OVF_W-1:0]  OVF_ADD    = OVF_W'(SCREEN + Columns);
	localparam logic [OVF_W-1:0]  STORE_O    = OVF_W'(tce_pkg::STORE_CELLS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_NEWLINE,
		ST_COPY,
		ST_ERASE,
		ST_PRINT,
		ST_WIPE,
		ST_RESULT
	} state_t;

	state_t                       state_q;
	logic [ADDR_W-1:0]            start_q;
	logic [ADDR_W-1:0]            cursor_q;
	logic [ADDR_W-1:0]            shown_q;
	logic [COL_W-1:0]             column_q;
	logic [LINE_W-1:0]            line_q;
	logic [PH_W-1:0]              phase_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         print_q;
	logic                         init_q;
	logic [tce_pkg::ATTR_W-1:0]   attr_q;
	logic [tce_pkg::CELL_W-1:0]   blank_q;

	logic [tce_pkg::OP_W-1:0]     op_q;
	logic [tce_pkg::BYTE_W-1:0]   byte_q;
	logic                         last_q;
	logic [ADDR_W-1:0]            addr_q;

	logic                         accept;
	logic [PH_W-1:0]              ph_inc;
	logic [PH_W-1:0]              ph_dec;
	logic [PH_W:0]                tab_step;
	logic [COL_W-1:0]             tab_col;
	logic [ADDR_W-1:0]            tab_cur;
	logic                         tab_wraps;
	logic                         wrap_now;
	logic                         ovf;
	logic [ADDR_W-1:0]            row_base;
	logic [ADDR_W-1:0]            shown_next;
	logic [tce_pkg::CELL_W-1:0]   wipe_word;
	logic [tce_pkg::CELL_W-1:0]   print_word;

	// Column modulo the tab stop moves back by a fixed amount when a row wraps.
	function automatic logic [PH_W-1:0] ph_wrap(input logic [PH_W-1:0] p);
		logic [PH_W:0] up;
		up = {1'b0, p} + TAB_P - {1'b0, PH_COL};
		if (p >= PH_COL) begin
			return p - PH_COL;
		end
		return up[PH_W-1:0];
	endfunction

	assign accept     = s_valid && s_ready;
	assign ph_inc     = (phase_q == PH_LAST) ? '0 : phase_q + 1'b1;
	assign ph_dec     = (phase_q == '0) ? PH_LAST : phase_q - 1'b1;
	assign tab_step   = TAB_P - {1'b0, phase_q};
	assign tab_col    = column_q + COL_W'(tab_step);
	assign tab_cur    = cursor_q + ADDR_W'(tab_step);
	assign tab_wraps  = tab_col >= COLS_C;
	assign wrap_now   = column_q >= COLS_C;
	assign ovf        = ({2'b00, start_q} + OVF_ADD) >= STORE_O;
	assign row_base   = start_q + SCREEN_A;
	assign wipe_word  = init_q ? tce_pkg::BLANK_RESET : blank_q;
	assign print_word = {attr_q, byte_q};

	always_comb begin
		if (op_q == tce_pkg::OP_WRITE && last_q) begin
			shown_next = cursor_q;
		end else if (op_q == tce_pkg::OP_CLEAR) begin
			shown_next = '0;
		end else begin
			shown_next = shown_q;
		end
	end

	assign s_ready   = (state_q == ST_IDLE) || (state_q == ST_RESULT && out_free);
	assign res.valid = (state_q == ST_RESULT) && out_free;
	assign res.shown = shown_next;
	assign res.start = start_q;
	assign res.data  = (op_q == tce_pkg::OP_READ) ? rdata : '0;

	// Cell store requests.
	always_comb begin
		mem_req = '0;
		unique case (state_q)
			ST_EXEC: begin
				if (op_q == tce_pkg::OP_READ) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = addr_q;
				end else if (op_q == tce_pkg::OP_WRITE) begin
					unique case (byte_q) inside
						tce_pkg::CH_NUL, tce_pkg::CH_HT, tce_pkg::CH_LF,
						tce_pkg::CH_VT, tce_pkg::CH_FF: begin
						end
						tce_pkg::CH_BS: begin
							mem_req.we    = (column_q != '0);
							mem_req.waddr = cursor_q - 1'b1;
							mem_req.wdata = blank_q;
						end
						tce_pkg::CH_DEL: begin
							mem_req.we    = 1'b1;
							mem_req.waddr = cursor_q;
							mem_req.wdata = blank_q;
						end
						default: begin
							mem_req.we    = !wrap_now;
							mem_req.waddr = cursor_q;
							mem_req.wdata = print_word;
						end
					endcase
				end
			end
			ST_COPY: begin
				// Read one cell ahead of the write; the source lies above the base.
				mem_req.re    = cnt_q < SCREEN_CNT;
				mem_req.raddr = start_q + cnt_q[ADDR_W-1:0];
				mem_req.we    = cnt_q != '0;
				mem_req.waddr = cnt_q[ADDR_W-1:0] - 1'b1;
				mem_req.wdata = rdata;
			end
			ST_ERASE: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = row_base + cnt_q[ADDR_W-1:0];
				mem_req.wdata = blank_q;
			end
			ST_PRINT: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = cursor_q;
				mem_req.wdata = print_word;
			end
			ST_WIPE: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = cnt_q[ADDR_W-1:0];
				mem_req.wdata = wipe_word;
			end
			default: begin
			end
		endcase
	end

	// Transaction fields, held while the operation runs.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_in;
			byte_q <= byte_in;
			last_q <= last_in;
			addr_q <= addr_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_WIPE;
			start_q  <= '0;
			cursor_q <= '0;
			shown_q  <= '0;
			column_q <= '0;
			line_q   <= '0;
			phase_q  <= '0;
			cnt_q    <= '0;
			print_q  <= 1'b0;
			init_q   <= 1'b1;
			attr_q   <= tce_pkg::ATTR_RESET;
			blank_q  <= tce_pkg::BLANK_RESET;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					tce_pkg::REG_TEXT_ATTR:  attr_q  <= cfg_wdata[tce_pkg::ATTR_W-1:0];
					tce_pkg::REG_BLANK_CELL: blank_q <= cfg_wdata[tce_pkg::CELL_W-1:0];
					default: begin
					end
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_RESULT;
					cnt_q   <= '0;
					print_q <= 1'b0;
					unique case (op_q)
						tce_pkg::OP_WRITE: begin
							unique case (byte_q) inside
								tce_pkg::CH_NUL, tce_pkg::CH_DEL: begin
								end
								tce_pkg::CH_BS: begin
									if (column_q != '0) begin
										column_q <= column_q - 1'b1;
										cursor_q <= cursor_q - 1'b1;
										phase_q  <= ph_dec;
									end
								end
								tce_pkg::CH_HT: begin
									if (tab_wraps) begin
										column_q <= tab_col - COLS_C;
										cursor_q <= tab_cur - COLS_A;
										phase_q  <= ph_wrap('0);
										state_q  <= ST_NEWLINE;
									end else begin
										column_q <= tab_col;
										cursor_q <= tab_cur;
										phase_q  <= '0;
									end
								end
								tce_pkg::CH_LF: begin
									cursor_q <= cursor_q - ADDR_W'(column_q);
									column_q <= '0;
									phase_q  <= '0;
									state_q  <= ST_NEWLINE;
								end
								tce_pkg::CH_VT, tce_pkg::CH_FF: begin
									state_q <= ST_NEWLINE;
								end
								default: begin
									if (wrap_now) begin
										// Full row: wrap first, print after the new line.
										column_q <= column_q - COLS_C;
										cursor_q <= cursor_q - COLS_A;
										phase_q  <= ph_wrap(phase_q);
										print_q  <= 1'b1;
										state_q  <= ST_NEWLINE;
									end else begin
										column_q <= column_q + 1'b1;
										cursor_q <= cursor_q + 1'b1;
										phase_q  <= ph_inc;
									end
								end
							endcase
						end
						tce_pkg::OP_CLEAR: begin
							start_q  <= '0;
							cursor_q <= '0;
							column_q <= '0;
							line_q   <= '0;
							phase_q  <= '0;
							state_q  <= ST_WIPE;
						end
						default: begin
						end
					endcase
				end
				ST_NEWLINE: begin
					cnt_q <= '0;
					if (line_q != LAST_LINE) begin
						line_q   <= line_q + 1'b1;
						cursor_q <= cursor_q + COLS_A;
						state_q  <= print_q ? ST_PRINT : ST_RESULT;
					end else begin
						state_q <= ovf ? ST_COPY : ST_ERASE;
					end
				end
				ST_COPY: begin
					if (cnt_q == SCREEN_CNT) begin
						cursor_q <= cursor_q - start_q;
						start_q  <= '0;
						cnt_q    <= '0;
						state_q  <= ST_ERASE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_ERASE: begin
					if (cnt_q == ERASE_LAST) begin
						start_q  <= start_q + COLS_A;
						cursor_q <= cursor_q + COLS_A;
						cnt_q    <= '0;
						state_q  <= print_q ? ST_PRINT : ST_RESULT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_PRINT: begin
					column_q <= column_q + 1'b1;
					cursor_q <= cursor_q + 1'b1;
					phase_q  <= ph_inc;
					state_q  <= ST_RESULT;
				end
				ST_WIPE: begin
					if (cnt_q[ADDR_W-1:0] == WIPE_LAST) begin
						cnt_q   <= '0;
						init_q  <= 1'b0;
						state_q <= init_q ? ST_IDLE : ST_RESULT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						shown_q <= shown_next;
						state_q <= s_valid ? ST_EXEC : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: design/tce_checker.sv
// ----------------------------------------------------------------------------
// tce_checker
// Port-level checks of the console engine, bound to the top level.
// ----------------------------------------------------------------------------
module tce_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [tce_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int USED_W = 2 * tce_pkg::ADDR_W + tce_pkg::CELL_W;

	logic       in_acc;
	logic       out_acc;
	logic [1:0] pend_q;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// Transactions taken in but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 2'd0)
		else $error("result without an outstanding transaction");

	a_one_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !out_acc |-> pend_q <= 2'd1)
		else $error("more than one transaction accepted ahead of delivery");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[tce_pkg::M_TDATA_W-1:USED_W] == '0)
		else $error("padding bits of result not zero");

endmodule

bind text_console_char_engine tce_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: bench/text_console_char_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_char_engine_tb
// Self-checking bench for the teletype console engine. A driver feeds queued
// operations in random bursts, a monitor stalls the result stream on shifting
// patterns, and a local model of the cell store, cursor and screen start
// predicts every result transaction, which is compared field by field.
// ----------------------------------------------------------------------------
module text_console_char_engine_tb;
	import tce_pkg::*;

	localparam int COLS   = COLUMNS_DEF;
	localparam int ROWS   = ROWS_DEF;
	localparam int TAB    = TAB_STOP_DEF;
	localparam int DEPTH  = STORE_CELLS;
	localparam int SCREEN = COLS * ROWS;
	localparam int REPORT_MAX = 100;
	localparam int PHASE_ITEMS = 200;

	// The block ignores this operation code apart from reporting its offsets.
	localparam logic [OP_W-1:0] OP_NONE = 2'd3;

	typedef enum logic [1:0] {AIM_ANY, AIM_CURSOR, AIM_SCREEN} read_aim_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [BYTE_W-1:0] ch;
		logic              last;
		logic [ADDR_W-1:0] addr;
		read_aim_t         aim;
	} console_txn_t;

	typedef struct packed {
		logic [ADDR_W-1:0] shown;
		logic [ADDR_W-1:0] start;
		logic [CELL_W-1:0] data;
	} console_view_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic [OP_W-1:0]       s_tuser = OP_WRITE;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_addr = REG_TEXT_ATTR;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	console_txn_t  console_items[$];
	console_view_t screen_expect[$];
	console_txn_t  on_bus;
	console_view_t want_view;
	int            error_count = 0;
	int            burst_left = 0;
	int            gap_left = 0;
	int            clears_left = 0;
	logic [15:0]   stall_bits = '1;
	logic [7:0]    stall_age = '0;

	// Mirror of the block state.
	logic [CELL_W-1:0] cell_mirror [DEPTH];
	int unsigned       top_off, cur_off, cur_col, cur_row, shown_off;
	logic [ATTR_W-1:0] attr_now;
	logic [CELL_W-1:0] blank_now;

	text_console_char_engine u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned wrap13(int unsigned v);
		return v % DEPTH;
	endfunction

	// When the next row would reach or run past the store end, the visible screen is
	// moved to the store base first, dragging the cursor along.
	function automatic void shift_screen_row();
		if (top_off + SCREEN + COLS >= DEPTH) begin
			for (int i = 0; i < SCREEN; i++)
				cell_mirror[i] = cell_mirror[top_off + i];
			cur_off = wrap13(cur_off + DEPTH - top_off);
			top_off = 0;
		end
		for (int i = 0; i < COLS; i++)
			cell_mirror[wrap13(top_off + SCREEN + i)] = blank_now;
		top_off = wrap13(top_off + COLS);
		cur_off = wrap13(cur_off + COLS);
	endfunction

	function automatic void advance_line();
		if (cur_row + 1 < ROWS) begin
			cur_row++;
			cur_off = wrap13(cur_off + COLS);
		end else begin
			shift_screen_row();
		end
	endfunction

	function automatic void wrap_long_row();
		if (cur_col >= COLS) begin
			cur_col -= COLS;
			cur_off = wrap13(cur_off + DEPTH - COLS);
			advance_line();
		end
	endfunction

	function automatic void put_byte(logic [BYTE_W-1:0] ch);
		int unsigned hop;
		case (ch)
			CH_NUL: ;
			CH_BS: if (cur_col != 0) begin
				cur_col--;
				cur_off = wrap13(cur_off + DEPTH - 1);
				cell_mirror[cur_off] = blank_now;
			end
			CH_HT: begin
				hop = TAB - (cur_col % TAB);
				cur_col += hop;
				cur_off = wrap13(cur_off + hop);
				wrap_long_row();
			end
			CH_LF: begin
				advance_line();
				cur_off = wrap13(cur_off + DEPTH - (cur_col % DEPTH));
				cur_col = 0;
			end
			CH_VT, CH_FF: advance_line();
			CH_DEL: cell_mirror[cur_off] = blank_now;
			default: begin
				wrap_long_row();
				cell_mirror[cur_off] = {attr_now, ch};
				cur_off = wrap13(cur_off + 1);
				cur_col++;
			end
		endcase
	endfunction

	function automatic console_view_t console_step(console_txn_t t);
		console_view_t v;
		v.data = '0;
		case (t.op)
			OP_WRITE: begin
				put_byte(t.ch);
				if (t.last)
					shown_off = cur_off;
			end
			OP_READ: v.data = cell_mirror[t.addr];
			OP_CLEAR: begin
				foreach (cell_mirror[i])
					cell_mirror[i] = blank_now;
				top_off = 0;
				cur_off = 0;
				cur_col = 0;
				cur_row = 0;
				shown_off = 0;
			end
			default: ;
		endcase
		v.shown = ADDR_W'(shown_off);
		v.start = ADDR_W'(top_off);
		return v;
	endfunction

	function automatic void push_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] ch, logic last,
			logic [ADDR_W-1:0] addr, read_aim_t aim);
		console_txn_t t;
		t.op = op;
		t.ch = ch;
		t.last = last;
		t.addr = addr;
		t.aim = aim;
		console_items.push_back(t);
	endfunction

	function automatic void flag_field(string name, int unsigned want, int unsigned got);
		error_count++;
		$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
	endfunction

	// Sender: bursts of random length separated by random gaps. Read targets
	// near the cursor or inside the screen or the row below it are resolved against the model
	// state at the moment the transaction is put on the bus.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready)
				screen_expect.push_back(console_step(on_bus));
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0 || console_items.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					s_tvalid <= 1'b0;
				end else begin
					on_bus = console_items.pop_front();
					if (on_bus.op == OP_READ && on_bus.aim == AIM_CURSOR)
						on_bus.addr = ADDR_W'(cur_off + DEPTH - $urandom_range(0, 99));
					else if (on_bus.op == OP_READ && on_bus.aim == AIM_SCREEN)
						on_bus.addr = ADDR_W'(top_off + $urandom_range(0, SCREEN + COLS - 1));
					s_tvalid <= 1'b1;
					s_tdata <= {3'b000, on_bus.addr, on_bus.ch};
					s_tuser <= on_bus.op;
					s_tlast <= on_bus.last;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end
	end

	// Receiver: ready follows a rotating bit pattern that is replaced each time
	// the stall age counter rolls over; a third of the patterns never stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_bits <= '1;
			stall_age <= '0;
		end else begin
			stall_age <= stall_age + 8'd1;
			if (stall_age == 8'hFF)
				stall_bits <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
			else
				stall_bits <= {stall_bits[0], stall_bits[15:1]};
			m_tready <= stall_bits[0];

			if (m_tvalid && m_tready) begin
				if (screen_expect.size() == 0) begin
					error_count++;
					if (error_count <= REPORT_MAX)
						$error("result transaction with nothing expected: m_tdata 0x%0h", m_tdata);
				end else begin
					want_view = screen_expect.pop_front();
					if (m_tdata[12:0] !== want_view.shown)
						flag_field("shown_cursor", want_view.shown, m_tdata[12:0]);
					if (m_tdata[25:13] !== want_view.start)
						flag_field("screen_start", want_view.start, m_tdata[25:13]);
					if (m_tdata[41:26] !== want_view.data)
						flag_field("cell_data", want_view.data, m_tdata[41:26]);
				end
			end
		end
	end

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		if (idx == REG_TEXT_ATTR)
			attr_now = value[ATTR_W-1:0];
		else
			blank_now = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (console_items.size() != 0 || s_tvalid || screen_expect.size() != 0)
			@(negedge clk);
	endtask

	// Random traffic made of text runs, runs of line feeds, reads and noise.
	// Line feeds are frequent so that the screen scrolls deep into the store.
	task automatic queue_random_phase(int count);
		int queued;
		int pick;
		int len;
		logic [BYTE_W-1:0] ch;
		queued = 0;
		while (queued < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 12);
				for (int k = 0; k < len; k++) begin
					case ($urandom_range(0, 11))
						0: ch = 8'($urandom);
						1: ch = CH_BS;
						2: ch = CH_HT;
						3: ch = CH_DEL;
						4: ch = 8'($urandom_range(128, 255));
						default: ch = 8'($urandom_range(32, 126));
					endcase
					push_item(OP_WRITE, ch, (k == len - 1) || ($urandom_range(0, 7) == 0),
						ADDR_W'($urandom), AIM_ANY);
				end
				queued += len;
			end else if (pick < 80) begin
				len = $urandom_range(1, 10);
				for (int k = 0; k < len; k++) begin
					case ($urandom_range(0, 4))
						0: ch = CH_VT;
						1: ch = CH_FF;
						default: ch = CH_LF;
					endcase
					push_item(OP_WRITE, ch, (k == len - 1) || ($urandom_range(0, 3) == 0),
						ADDR_W'($urandom), AIM_ANY);
				end
				queued += len;
			end else if (pick < 94) begin
				len = $urandom_range(1, 4);
				for (int k = 0; k < len; k++)
					push_item(OP_READ, 8'($urandom), 1'($urandom), ADDR_W'($urandom),
						read_aim_t'($urandom_range(0, 2)));
				queued += len;
			end else if (pick < 98) begin
				push_item(OP_NONE, 8'($urandom), 1'($urandom), ADDR_W'($urandom), AIM_ANY);
				queued++;
			end else if (clears_left > 0) begin
				clears_left--;
				push_item(OP_CLEAR, 8'($urandom), 1'($urandom), ADDR_W'($urandom), AIM_ANY);
				queued++;
			end
		end
	endtask

	initial begin
		logic [ATTR_W-1:0] attr_pick;
		logic [CELL_W-1:0] blank_pick;
		foreach (cell_mirror[i])
			cell_mirror[i] = BLANK_RESET;
		top_off = 0;
		cur_off = 0;
		cur_col = 0;
		cur_row = 0;
		shown_off = 0;
		attr_now = ATTR_RESET;
		blank_now = BLANK_RESET;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// The block is still blanking its store, so write the reset values.
		write_register(REG_TEXT_ATTR, CFG_DATA_W'(ATTR_RESET));
		write_register(REG_BLANK_CELL, BLANK_RESET);
		@(negedge clk);

		// Directed: control bytes, backspace at column zero, a row filled to
		// its end with tabs and printables, then actions just past the row end.
		push_item(OP_WRITE, CH_NUL, 1'b0, '0, AIM_ANY);
		push_item(OP_WRITE, CH_BS, 1'b0, '0, AIM_ANY);
		push_item(OP_WRITE, 8'h41, 1'b0, '0, AIM_ANY);
		push_item(OP_WRITE, CH_BS, 1'b1, '0, AIM_ANY);
		repeat (9)
			push_item(OP_WRITE, CH_HT, 1'b0, '0, AIM_ANY);
		push_item(OP_WRITE, 8'h0D, 1'b0, '0, AIM_ANY);
		push_item(OP_WRITE, 8'h07, 1'b0, '0, AIM_ANY);
		push_item(OP_WRITE, 8'hFF, 1'b0, '0, AIM_ANY);
		push_item(OP_WRITE, 8'h01, 1'b0, '1, AIM_ANY);
		push_item(OP_WRITE, 8'h80, 1'b0, '0, AIM_ANY);
		push_item(OP_WRITE, 8'h20, 1'b0, '0, AIM_ANY);
		push_item(OP_WRITE, 8'h7E, 1'b0, '0, AIM_ANY);
		push_item(OP_WRITE, 8'h5A, 1'b1, '0, AIM_ANY);
		push_item(OP_WRITE, CH_BS, 1'b0, '0, AIM_ANY);
		push_item(OP_WRITE, 8'h41, 1'b0, '0, AIM_ANY);
		push_item(OP_WRITE, CH_DEL, 1'b1, '0, AIM_ANY);
		push_item(OP_WRITE, 8'h42, 1'b1, '0, AIM_ANY);
		push_item(OP_WRITE, CH_LF, 1'b1, '0, AIM_ANY);
		push_item(OP_WRITE, CH_VT, 1'b0, '0, AIM_ANY);
		push_item(OP_WRITE, CH_FF, 1'b1, '0, AIM_ANY);
		push_item(OP_READ, 8'h00, 1'b0, '0, AIM_ANY);
		push_item(OP_READ, 8'hFF, 1'b1, '1, AIM_ANY);
		push_item(OP_READ, 8'h00, 1'b0, '0, AIM_CURSOR);
		push_item(OP_NONE, 8'hFF, 1'b1, '1, AIM_ANY);
		push_item(OP_CLEAR, 8'hFF, 1'b1, '1, AIM_ANY);
		push_item(OP_READ, 8'h00, 1'b0, '0, AIM_SCREEN);
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					attr_pick = 8'hFF;
					blank_pick = 16'hFFFF;
				end
				1: begin
					attr_pick = 8'h00;
					blank_pick = 16'h0000;
				end
				2: begin
					attr_pick = 8'($urandom);
					blank_pick = 16'($urandom);
				end
				default: begin
					attr_pick = 8'($urandom);
					blank_pick = BLANK_RESET;
					clears_left = 1;
				end
			endcase
			write_register(REG_TEXT_ATTR, CFG_DATA_W'(attr_pick));
			write_register(REG_BLANK_CELL, blank_pick);
			@(negedge clk);
			queue_random_phase(PHASE_ITEMS);
			wait_drained();
		end

		repeat (24) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Far beyond the slowest correct run, clears and full copies included.
	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
